/* rtl/speck_48_72_block_cipher_assert.svh */
// ----------------------------------------------------------------------------
// Speck 48/72 assertion macros
// Assertion macros used by the Speck 48/72 block cipher module.
// ----------------------------------------------------------------------------
`ifndef SPECK_48_72_BLOCK_CIPHER_ASSERT_SVH
`define SPECK_48_72_BLOCK_CIPHER_ASSERT_SVH

// Checked only while the block is out of reset.
`define SPECK_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SPECK_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/speck_pkg.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 package
// Word types, stage state, rotations and the key schedule functions.
// ----------------------------------------------------------------------------
package speck_pkg;

    localparam int WORD_W = 24;
    localparam int ROUNDS = 22;
    localparam int STAGES = 2 * ROUNDS;
    localparam int RIDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int ROT_A  = 8;
    localparam int ROT_B  = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [RIDX_W-1:0] t_ridx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        t_op   op;
        t_word x;
        t_word y;
        t_word k;
        t_word la;
        t_word lb;
    } t_stage;

    function automatic t_word ror_a(input t_word w);
        return (w >> ROT_A) | (w << (WORD_W - ROT_A));
    endfunction

    function automatic t_word rol_a(input t_word w);
        return (w << ROT_A) | (w >> (WORD_W - ROT_A));
    endfunction

    function automatic t_word ror_b(input t_word w);
        return (w >> ROT_B) | (w << (WORD_W - ROT_B));
    endfunction

    function automatic t_word rol_b(input t_word w);
        return (w << ROT_B) | (w >> (WORD_W - ROT_B));
    endfunction

    // One forward key schedule step; the round key of this round is s.k.
    function automatic t_stage key_fwd(input t_stage s, input t_ridx idx);
        t_stage o;
        t_word  t;
        o    = s;
        t    = (ror_a(s.la) + s.k) ^ t_word'(idx);
        o.k  = rol_b(s.k) ^ t;
        o.la = s.lb;
        o.lb = t;
        return o;
    endfunction

    // Undoes one key schedule step; the result's k is the round key of idx.
    function automatic t_stage key_bwd(input t_stage s, input t_ridx idx);
        t_stage o;
        o    = s;
        o.k  = ror_b(s.k ^ s.lb);
        o.la = rol_a((s.lb ^ t_word'(idx)) - o.k);
        o.lb = s.la;
        return o;
    endfunction

endpackage

/* rtl/speck_in_if.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 input channel
// Carries one request word: mode, three key words and the block.
// ----------------------------------------------------------------------------
interface speck_in_if;
    import speck_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_word key_low;
    t_word key_mid;
    t_word key_high;
    t_word block_x;
    t_word block_y;

    modport source (
        output valid, op, key_low, key_mid, key_high, block_x, block_y,
        input  ready
    );

    modport sink (
        input  valid, op, key_low, key_mid, key_high, block_x, block_y,
        output ready
    );
endinterface

/* rtl/speck_out_if.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 output channel
// Carries one result word: the encrypted or decrypted block.
// ----------------------------------------------------------------------------
interface speck_out_if;
    import speck_pkg::*;

    logic  valid;
    logic  ready;
    t_word out_x;
    t_word out_y;

    modport source (
        output valid, out_x, out_y,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y,
        output ready
    );
endinterface

/* rtl/speck_48_72_block_cipher.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 block cipher
// Fully unrolled pipeline; encrypts or decrypts one block per unstalled cycle.
// ----------------------------------------------------------------------------
// Each word on i_in carries the mode, the three key words and the block; each
// word on o_out carries the resulting block. Both channels use valid/ready.
// The pipeline has 44 register stages. The first 22 run the key schedule
// forward, one step per stage, and apply the encryption rounds beside it. The
// last 22 run the key schedule backward from its final state, so the round
// keys appear in reverse order, and apply the decryption rounds beside it.
// A block's result reaches o_out after its word has passed every stage. A new
// word can be accepted on every cycle in which the pipeline is not stalled, so
// throughput is one block per cycle. The last stage is the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// i_in.ready drops; words in flight are neither lost nor repeated. Empty
// stages do not close up during a stall.
// Reset clears all stage valid bits; the block accepts a word in the first
// cycle after reset.
// ----------------------------------------------------------------------------
`include "speck_48_72_block_cipher_assert.svh"

module speck_48_72_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    speck_in_if.sink    i_in,
    speck_out_if.source o_out
);
    import speck_pkg::*;

    t_stage              w_src [STAGES];
    t_stage              n_st  [STAGES];
    t_stage              r_st  [STAGES];
    logic [STAGES-1:0]   r_valid;
    logic [STAGES-1:0]   n_valid;
    logic                w_advance;

    assign w_advance = !r_valid[STAGES-1] || o_out.ready;
    assign i_in.ready = w_advance;

    always_comb begin
        w_src[0].op = t_op'(i_in.op);
        w_src[0].x  = i_in.block_x;
        w_src[0].y  = i_in.block_y;
        w_src[0].k  = i_in.key_high;
        w_src[0].la = i_in.key_mid;
        w_src[0].lb = i_in.key_low;
    end

    for (genvar s = 1; s < STAGES; s++) begin : g_link
        assign w_src[s] = r_st[s-1];
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        if (s < ROUNDS) begin : g_fwd
            always_comb begin
                n_st[s] = key_fwd(w_src[s], RIDX_W'(s));
                if (w_src[s].op == OP_ENCRYPT) begin
                    n_st[s].x = (ror_a(w_src[s].x) + w_src[s].y) ^ w_src[s].k;
                    n_st[s].y = rol_b(w_src[s].y) ^ n_st[s].x;
                end else begin
                    n_st[s].x = w_src[s].x;
                    n_st[s].y = w_src[s].y;
                end
            end
        end else begin : g_bwd
            always_comb begin
                n_st[s] = key_bwd(w_src[s], RIDX_W'(STAGES - 1 - s));
                if (w_src[s].op == OP_DECRYPT) begin
                    n_st[s].y = ror_b(w_src[s].y ^ w_src[s].x);
                    n_st[s].x = rol_a((w_src[s].x ^ n_st[s].k) - n_st[s].y);
                end else begin
                    n_st[s].x = w_src[s].x;
                    n_st[s].y = w_src[s].y;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_advance) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_comb begin
        n_valid = {r_valid[STAGES-2:0], i_in.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_advance) begin
            r_valid <= n_valid;
        end
    end

    assign o_out.valid = r_valid[STAGES-1];
    assign o_out.out_x = r_st[STAGES-1].x;
    assign o_out.out_y = r_st[STAGES-1].y;

    `SPECK_ASSERT_ALL(a_reset_clears, !i_rst_n |=> (r_valid == '0), "valid bits survive reset")
    `SPECK_ASSERT_RUN(a_accept_loads, (i_in.valid && i_in.ready) |=> r_valid[0], "accepted word lost")
    `SPECK_ASSERT_RUN(a_stall_holds, !w_advance |=> $stable(r_valid), "pipeline moved during stall")
    `SPECK_ASSERT_RUN(a_out_origin, $rose(o_out.valid) |-> $past(r_valid[STAGES-2]), "result from nowhere")

endmodule

/* dv/speck_48_72_block_cipher_checker.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 result checker
// Watches both channels, computes the expected block for every accepted
// request word and compares it with the result words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speck_48_72_block_cipher_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    speck_in_if   i_in,
    speck_out_if  i_out,
    output int    o_errors,
    output int    o_pending
);
    import speck_pkg::*;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_block;

    t_block expected_blocks[$];
    int     mismatch_count;

    function automatic t_word word_rotl(input t_word w, input int s);
        logic [2*WORD_W-1:0] twice;
        twice = {w, w} >> (WORD_W - s);
        return twice[WORD_W-1:0];
    endfunction

    function automatic t_word word_rotr(input t_word w, input int s);
        logic [2*WORD_W-1:0] twice;
        twice = {w, w} >> s;
        return twice[WORD_W-1:0];
    endfunction

    function automatic t_block speck_cipher(input t_op op, input t_word key_low,
                                            input t_word key_mid, input t_word key_high,
                                            input t_word x_in, input t_word y_in);
        t_word  round_key[ROUNDS];
        t_word  sched_first;
        t_word  sched_second;
        t_word  sched_key;
        t_word  sched_tmp;
        t_word  x;
        t_word  y;
        t_block res;
        sched_first  = key_mid;
        sched_second = key_low;
        sched_key    = key_high;
        for (int i = 0; i < ROUNDS; i++) begin
            round_key[i] = sched_key;
            sched_tmp    = (word_rotr(sched_first, ROT_A) + sched_key) ^ t_word'(i);
            sched_key    = word_rotl(sched_key, ROT_B) ^ sched_tmp;
            sched_first  = sched_second;
            sched_second = sched_tmp;
        end
        x = x_in;
        y = y_in;
        if (op == OP_ENCRYPT) begin
            for (int i = 0; i < ROUNDS; i++) begin
                x = (word_rotr(x, ROT_A) + y) ^ round_key[i];
                y = word_rotl(y, ROT_B) ^ x;
            end
        end else begin
            for (int i = ROUNDS - 1; i >= 0; i--) begin
                y = word_rotr(y ^ x, ROT_B);
                x = word_rotl((x ^ round_key[i]) - y, ROT_A);
            end
        end
        res.x = x;
        res.y = y;
        return res;
    endfunction

    initial begin
        mismatch_count = 0;
    end

    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("Result word with nothing expected: out_x %06h, out_y %06h",
                           i_out.out_x, i_out.out_y);
                    mismatch_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (i_out.out_x !== want.x) begin
                        $error("out_x mismatch: expected %06h, actual %06h",
                               want.x, i_out.out_x);
                        mismatch_count++;
                    end
                    if (i_out.out_y !== want.y) begin
                        $error("out_y mismatch: expected %06h, actual %06h",
                               want.y, i_out.out_y);
                        mismatch_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_blocks.push_back(speck_cipher(t_op'(i_in.op), i_in.key_low,
                                                       i_in.key_mid, i_in.key_high,
                                                       i_in.block_x, i_in.block_y));
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_blocks.size();
    end

endmodule

/* dv/speck_48_72_block_cipher_tb.sv */
// ----------------------------------------------------------------------------
// Speck 48/72 block cipher testbench
// Sends directed and random encrypt and decrypt words with random idle and
// stall bursts on both channels; a separate checker predicts every block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speck_48_72_block_cipher_tb;
    import speck_pkg::*;

    localparam int          RANDOM_WORDS = 750;
    localparam int          QUIET_WORDS  = 100;
    localparam int          DRAIN_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned gap_pct = 0;
    int unsigned cycle_count = 0;
    int          error_count;
    int          pending_count;
    t_word       key_low_r;
    t_word       key_mid_r;
    t_word       key_high_r;

    speck_in_if  req_ch ();
    speck_out_if res_ch ();

    speck_48_72_block_cipher DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    speck_48_72_block_cipher_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (req_ch),
        .i_out     (res_ch),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[speck_48_72_block_cipher] ERROR");
            $finish;
        end
    end

    initial begin
        forever begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic send_word(input t_op op, input t_word key_low, input t_word key_mid,
                             input t_word key_high, input t_word x, input t_word y);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.key_low  <= key_low;
        req_ch.key_mid  <= key_mid;
        req_ch.key_high <= key_high;
        req_ch.block_x  <= x;
        req_ch.block_y  <= y;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_op pick_op();
        return ($urandom_range(0, 1) == 1) ? OP_DECRYPT : OP_ENCRYPT;
    endfunction

    initial begin
        t_word bit_hi;
        t_word bit_lo;
        bit_hi = t_word'(1) << (WORD_W - 1);
        bit_lo = t_word'(1);

        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_ENCRYPT;
        req_ch.key_low  <= '0;
        req_ch.key_mid  <= '0;
        req_ch.key_high <= '0;
        req_ch.block_x  <= '0;
        req_ch.block_y  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_ENCRYPT, '0, '0, '0, '0, '0);
        send_word(OP_DECRYPT, '0, '0, '0, '0, '0);
        send_word(OP_ENCRYPT, '1, '1, '1, '1, '1);
        send_word(OP_DECRYPT, '1, '1, '1, '1, '1);
        send_word(OP_ENCRYPT, 24'h121110, 24'h0a0908, 24'h020100, 24'h20796c, 24'h6c6172);
        send_word(OP_DECRYPT, 24'h121110, 24'h0a0908, 24'h020100, 24'hc049a5, 24'h385adc);
        send_word(OP_ENCRYPT, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa);
        send_word(OP_DECRYPT, 24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555);
        send_word(OP_ENCRYPT, bit_hi, '0, '0, '0, '0);
        send_word(OP_ENCRYPT, '0, bit_hi, '0, '0, '0);
        send_word(OP_ENCRYPT, '0, '0, bit_hi, '0, '0);
        send_word(OP_ENCRYPT, '0, '0, '0, bit_hi, '0);
        send_word(OP_ENCRYPT, '0, '0, '0, '0, bit_hi);
        send_word(OP_DECRYPT, bit_lo, '0, '0, '0, '0);
        send_word(OP_DECRYPT, '0, bit_lo, '0, '0, '0);
        send_word(OP_DECRYPT, '0, '0, bit_lo, '0, '0);
        send_word(OP_DECRYPT, '0, '0, '0, bit_lo, '0);
        send_word(OP_DECRYPT, '0, '0, '0, '0, bit_lo);
        wait_all_results();

        key_low_r  = pick_word();
        key_mid_r  = pick_word();
        key_high_r = pick_word();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n >= RANDOM_WORDS - QUIET_WORDS) begin
                gap_pct = 0;
            end else if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    2:       gap_pct = 30;
                    default: gap_pct = 60;
                endcase
            end
            if (n == RANDOM_WORDS / 2) begin
                wait_all_results();
            end
            if ($urandom_range(0, 2) != 0) begin
                key_low_r  = pick_word();
                key_mid_r  = pick_word();
                key_high_r = pick_word();
            end
            send_word(pick_op(), key_low_r, key_mid_r, key_high_r, pick_word(), pick_word());
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("[speck_48_72_block_cipher] OK");
        end else begin
            $display("[speck_48_72_block_cipher] ERROR");
        end
        $finish;
    end

endmodule
